@@ hw/rtl/nps_pkg.sv @@
package nps_pkg;

    // Width of the query value; the prime above needs one bit more.
    localparam int VALUE_WIDTH = 16;
    localparam int CAND_WIDTH  = VALUE_WIDTH + 1;
    // Divisor and its square are kept one bit wider than a candidate, so that
    // the square of the first divisor past the square root still fits.
    localparam int DIV_WIDTH   = VALUE_WIDTH + 2;
    localparam int CNT_WIDTH   = $clog2(CAND_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [CAND_WIDTH-1:0]  cand_t;
    typedef logic [DIV_WIDTH-1:0]   divw_t;
    typedef logic [CNT_WIDTH-1:0]   cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BELOW_SETUP,
        ST_TEST_INIT,
        ST_TEST_CHECK,
        ST_DIV,
        ST_DIV_DONE,
        ST_ABOVE_SETUP,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic load_query;
        logic init_below;
        logic init_above;
        logic init_test;
        logic start_div;
        logic div_step;
        logic next_divisor;
        logic cand_dec;
        logic cand_inc;
        logic save_below;
        logic save_above;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic q_lt2;
        logic q_lt3;
        logic sq_gt_cand;
        logic div_last;
        logic rem_zero;
    } sts_t;

endpackage

@@ hw/rtl/nps_in_if.sv @@
interface nps_in_if import nps_pkg::*;;
    logic   valid;
    logic   ready;
    value_t query_value;

    modport source (output valid, output query_value, input ready);
    modport sink   (input valid, input query_value, output ready);
endinterface

@@ hw/rtl/nps_out_if.sv @@
interface nps_out_if import nps_pkg::*;;
    logic   valid;
    logic   ready;
    value_t prime_below;
    logic   below_found;
    cand_t  prime_above;
    logic   above_found;

    modport source (output valid, output prime_below, output below_found,
                    output prime_above, output above_found, input ready);
    modport sink   (input valid, input prime_below, input below_found,
                    input prime_above, input above_found, output ready);
endinterface

@@ hw/rtl/nearest_prime_search.sv @@
// Channel   Role    Payload                                          Handshake
// query     sink    query_value                                      valid/ready
// result    source  prime_below, below_found, prime_above, above_found valid/ready
//
// The time per query depends on the data and is set by the trial-division
// loop: every trial divisor passes through a check, one restoring division
// step per candidate bit and a remainder test; every candidate adds one step.
// Reset leaves the block idle with no result pending; there is no clearing pass.
// A finished result sits in the output register while the next query is taken
// and searched; the block stalls only when a new result is ready and the old
// one has still not been taken.
module nearest_prime_search import nps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    nps_in_if.sink       query,
    nps_out_if.source    result
);

    // The controller walks the candidates: first downward from the query for the
    // prime below, then upward for the prime above. For every candidate it
    // tries divisors d = 2, 3, ... while d*d does not exceed the candidate; a
    // zero remainder rejects the candidate, a divisor past the square root
    // accepts it. A prime above always exists below twice the query from two
    // upward, which lies inside the square bound, so only queries zero and one
    // report no prime above.
    cmd_t cmd;
    sts_t sts;

    nps_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query.valid),
        .query_ready  (query.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    nps_datapath u_datapath
    (
        .clk         (clk),
        .cmd         (cmd),
        .sts         (sts),
        .query_value (query.query_value),
        .prime_below (result.prime_below),
        .below_found (result.below_found),
        .prime_above (result.prime_above),
        .above_found (result.above_found)
    );

    // A result whose flag is clear must read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.below_found) |-> (result.prime_below == '0))
        else $error("prime_below nonzero without below_found");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.above_found) |-> (result.prime_above == '0))
        else $error("prime_above nonzero without above_found");

    // Once a query is taken the block is busy searching in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (query.valid && query.ready) |=> !query.ready)
        else $error("query taken while a search was starting");

    // A new result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> !(result.valid && !result.ready))
        else $error("result overwritten before it was taken");

endmodule

@@ hw/rtl/nps_datapath.sv @@
module nps_datapath import nps_pkg::*;
(
    input  logic   clk,
    input  cmd_t   cmd,
    output sts_t   sts,
    input  value_t query_value,
    output value_t prime_below,
    output logic   below_found,
    output cand_t  prime_above,
    output logic   above_found
);

    value_t query_reg,   query_next;
    cand_t  cand_reg,    cand_next;
    divw_t  d_reg,       d_next;
    divw_t  sq_reg,      sq_next;
    divw_t  rem_reg,     rem_next;
    cand_t  shift_reg,   shift_next;
    cnt_t   cnt_reg,     cnt_next;
    value_t below_reg,   below_next;
    logic   bfound_reg,  bfound_next;
    cand_t  above_reg,   above_next;
    logic   afound_reg,  afound_next;
    value_t out_below_reg,  out_below_next;
    logic   out_bfound_reg, out_bfound_next;
    cand_t  out_above_reg,  out_above_next;
    logic   out_afound_reg, out_afound_next;

    logic [DIV_WIDTH:0] trial;
    logic               trial_ge;
    divw_t              rem_step;

    // One step of restoring division: bring down the next candidate bit.
    assign trial    = {rem_reg, shift_reg[CAND_WIDTH-1]};
    assign trial_ge = trial >= {1'b0, d_reg};
    assign rem_step = trial_ge ? DIV_WIDTH'(trial - {1'b0, d_reg})
                               : trial[DIV_WIDTH-1:0];

    always_comb
    begin
        query_next      = query_reg;
        cand_next       = cand_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        rem_next        = rem_reg;
        shift_next      = shift_reg;
        cnt_next        = cnt_reg;
        below_next      = below_reg;
        bfound_next     = bfound_reg;
        above_next      = above_reg;
        afound_next     = afound_reg;
        out_below_next  = out_below_reg;
        out_bfound_next = out_bfound_reg;
        out_above_next  = out_above_reg;
        out_afound_next = out_afound_reg;

        if (cmd.load_query)
        begin
            query_next  = query_value;
            below_next  = '0;
            bfound_next = 1'b0;
            above_next  = '0;
            afound_next = 1'b0;
        end
        if (cmd.init_below)
        begin
            cand_next = {1'b0, query_reg - value_t'(1)};
        end
        if (cmd.init_above)
        begin
            cand_next = {1'b0, query_reg} + cand_t'(1);
        end
        if (cmd.cand_dec)
        begin
            cand_next = cand_reg - cand_t'(1);
        end
        if (cmd.cand_inc)
        begin
            cand_next = cand_reg + cand_t'(1);
        end
        if (cmd.init_test)
        begin
            d_next  = divw_t'(2);
            sq_next = divw_t'(4);
        end
        if (cmd.next_divisor)
        begin
            // (d + 1)^2 = d^2 + 2d + 1
            d_next  = d_reg + divw_t'(1);
            sq_next = sq_reg + (d_reg << 1) + divw_t'(1);
        end
        if (cmd.start_div)
        begin
            rem_next   = '0;
            shift_next = cand_reg;
            cnt_next   = '0;
        end
        if (cmd.div_step)
        begin
            rem_next   = rem_step;
            shift_next = shift_reg << 1;
            cnt_next   = cnt_reg + cnt_t'(1);
        end
        if (cmd.save_below)
        begin
            below_next  = cand_reg[VALUE_WIDTH-1:0];
            bfound_next = 1'b1;
        end
        if (cmd.save_above)
        begin
            above_next  = cand_reg;
            afound_next = 1'b1;
        end
        if (cmd.publish)
        begin
            out_below_next  = below_reg;
            out_bfound_next = bfound_reg;
            out_above_next  = above_reg;
            out_afound_next = afound_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg      <= query_next;
        cand_reg       <= cand_next;
        d_reg          <= d_next;
        sq_reg         <= sq_next;
        rem_reg        <= rem_next;
        shift_reg      <= shift_next;
        cnt_reg        <= cnt_next;
        below_reg      <= below_next;
        bfound_reg     <= bfound_next;
        above_reg      <= above_next;
        afound_reg     <= afound_next;
        out_below_reg  <= out_below_next;
        out_bfound_reg <= out_bfound_next;
        out_above_reg  <= out_above_next;
        out_afound_reg <= out_afound_next;
    end

    assign sts.q_lt2      = query_reg < value_t'(2);
    assign sts.q_lt3      = query_reg < value_t'(3);
    assign sts.sq_gt_cand = sq_reg > {1'b0, cand_reg};
    assign sts.div_last   = cnt_reg == cnt_t'(CAND_WIDTH - 1);
    assign sts.rem_zero   = rem_reg == '0;

    assign prime_below = out_below_reg;
    assign below_found = out_bfound_reg;
    assign prime_above = out_above_reg;
    assign above_found = out_afound_reg;

endmodule

@@ hw/rtl/nps_ctrl.sv @@
module nps_ctrl import nps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic query_valid,
    output logic query_ready,
    output logic result_valid,
    input  logic result_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg, state_next;
    logic   above_reg, above_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_publish;

    assign can_publish = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        above_next = above_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_valid)
                begin
                    state_next = ST_BELOW_SETUP;
                end
            end
            ST_BELOW_SETUP:
            begin
                above_next = 1'b0;
                state_next = sts.q_lt3 ? ST_ABOVE_SETUP : ST_TEST_INIT;
            end
            ST_TEST_INIT:
            begin
                state_next = ST_TEST_CHECK;
            end
            ST_TEST_CHECK:
            begin
                if (!sts.sq_gt_cand)
                begin
                    state_next = ST_DIV;
                end
                else if (above_reg)
                begin
                    state_next = ST_PUBLISH;
                end
                else
                begin
                    state_next = ST_ABOVE_SETUP;
                end
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE:
            begin
                state_next = sts.rem_zero ? ST_TEST_INIT : ST_TEST_CHECK;
            end
            ST_ABOVE_SETUP:
            begin
                above_next = 1'b1;
                state_next = sts.q_lt2 ? ST_PUBLISH : ST_TEST_INIT;
            end
            ST_PUBLISH:
            begin
                if (can_publish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        query_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                query_ready    = 1'b1;
                cmd.load_query = query_valid;
            end
            ST_BELOW_SETUP:
            begin
                cmd.init_below = !sts.q_lt3;
            end
            ST_TEST_INIT:
            begin
                cmd.init_test = 1'b1;
            end
            ST_TEST_CHECK:
            begin
                cmd.start_div  = !sts.sq_gt_cand;
                cmd.save_below = sts.sq_gt_cand && !above_reg;
                cmd.save_above = sts.sq_gt_cand && above_reg;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DIV_DONE:
            begin
                cmd.cand_dec     = sts.rem_zero && !above_reg;
                cmd.cand_inc     = sts.rem_zero && above_reg;
                cmd.next_divisor = !sts.rem_zero;
            end
            ST_ABOVE_SETUP:
            begin
                cmd.init_above = !sts.q_lt2;
            end
            ST_PUBLISH:
            begin
                cmd.publish = can_publish;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            above_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            above_reg     <= above_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

@@ test/nearest_prime_search_tb.sv @@
module nearest_prime_search_tb;
    import nps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is slow: a query near the top of the range tests two large
    // primes with some 256 trial divisors each, each one a full restoring
    // division. The slowest query stays far below QUIET_LIMIT, so this many
    // quiet cycles in a row can only mean a hang.
    localparam int unsigned QUIET_LIMIT   = 400000;
    // No query ends without a result, so a short wait at the end is enough
    // to catch any stray result the block might still emit.
    localparam int unsigned DRAIN_CYCLES  = 64;
    localparam int unsigned RANDOM_ITEMS  = 80;
    localparam int unsigned DIRECTED_ROWS = 21;

    // One result item, laid out as the output channel carries it.
    typedef struct packed {
        value_t prime_below;
        logic   below_found;
        cand_t  prime_above;
        logic   above_found;
    } prime_pair_t;

    // A row of directed stimulus. When fixed is set, the expected result is
    // the one typed into the row; otherwise the predictor supplies it.
    typedef struct packed {
        value_t      query_value;
        logic        fixed;
        prime_pair_t want;
    } query_row_t;

    // The receiver draws a new behavior whenever its phase counter wraps.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_PATTERN,
        RX_SPARSE,
        RX_COIN
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    nps_in_if  query_ch ();
    nps_out_if result_ch ();

    nearest_prime_search uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    always #4 clk = ~clk;

    // Directed queries. The rows with a typed expectation are the ones that
    // can be read off by hand: the values below three, where no prime lies
    // below, the values zero and one, where the square bound leaves nothing
    // above, three and four, and the top of the range, whose neighbors are
    // the largest 16-bit prime and 65537. The rest cover values inside wide
    // prime gaps, primes as queries, powers of two and alternating bits.
    query_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'd0,     1'b1, '{16'd0,     1'b0, 17'd0,     1'b0}},
        '{16'd1,     1'b1, '{16'd0,     1'b0, 17'd0,     1'b0}},
        '{16'd2,     1'b1, '{16'd0,     1'b0, 17'd3,     1'b1}},
        '{16'd3,     1'b1, '{16'd2,     1'b1, 17'd5,     1'b1}},
        '{16'd4,     1'b1, '{16'd3,     1'b1, 17'd5,     1'b1}},
        '{16'd65535, 1'b1, '{16'd65521, 1'b1, 17'd65537, 1'b1}},
        '{16'd5,     1'b0, '0},
        '{16'd6,     1'b0, '0},
        '{16'd7,     1'b0, '0},
        '{16'd24,    1'b0, '0},
        '{16'd114,   1'b0, '0},
        '{16'd255,   1'b0, '0},
        '{16'd256,   1'b0, '0},
        '{16'h5555,  1'b0, '0},
        '{16'hAAAA,  1'b0, '0},
        '{16'd31433, 1'b0, '0},
        '{16'd32767, 1'b0, '0},
        '{16'd32768, 1'b0, '0},
        '{16'd65520, 1'b0, '0},
        '{16'd65521, 1'b0, '0},
        '{16'd65534, 1'b0, '0}
    };

    // Results still owed by the block, oldest first.
    prime_pair_t owed_primes [$];
    int unsigned fail_count  = 0;
    int unsigned quiet_count = 0;

    // These travel alongside the query payload, so that the checker sees
    // the typed expectation of a row in the same cycle as its query.
    logic        offer_fixed;
    prime_pair_t offer_want;

    // Trial division: at least two and no divisor up to the square root.
    function automatic bit is_prime(longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 1'b0;
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Nearest primes on either side of a query. The upward search is
    // bounded by the square of the query, which is what leaves zero and one
    // with no prime above.
    function automatic prime_pair_t nearest_primes(value_t q);
        longint unsigned qv;
        longint unsigned c;
        longint unsigned bound;
        prime_pair_t     r;
        r  = '0;
        qv = q;
        for (c = qv; c > 1; c--)
        begin
            if (is_prime(c - 1))
            begin
                r.prime_below = value_t'(c - 1);
                r.below_found = 1'b1;
                break;
            end
        end
        bound = qv * qv;
        for (c = qv + 1; c < bound; c++)
        begin
            if (is_prime(c))
            begin
                r.prime_above = cand_t'(c);
                r.above_found = 1'b1;
                break;
            end
        end
        return r;
    endfunction

    // Most random queries are small, since the search time grows with the
    // square root of the value. A share spans the full range so that every
    // bit of the query takes both values.
    function automatic value_t pick_query();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return value_t'($urandom_range(0, 255));
        else if (sel < 85)
            return value_t'($urandom_range(0, 4095));
        else
            return value_t'($urandom_range(0, 65535));
    endfunction

    // Checker and scoreboard in one process. A result accepted in the same
    // cycle as a query belongs to an older query, so the result is matched
    // before the new expectation is queued.
    always @(posedge clk)
    begin
        prime_pair_t got;
        prime_pair_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.prime_below, result_ch.below_found,
                        result_ch.prime_above, result_ch.above_found};
                if (owed_primes.size() == 0)
                begin
                    $error("result item with no query outstanding");
                    fail_count++;
                end
                else
                begin
                    want = owed_primes.pop_front();
                    if (got.prime_below !== want.prime_below)
                    begin
                        $error("prime_below: expected %0d, got %0d",
                               want.prime_below, got.prime_below);
                        fail_count++;
                    end
                    if (got.below_found !== want.below_found)
                    begin
                        $error("below_found: expected %0d, got %0d",
                               want.below_found, got.below_found);
                        fail_count++;
                    end
                    if (got.prime_above !== want.prime_above)
                    begin
                        $error("prime_above: expected %0d, got %0d",
                               want.prime_above, got.prime_above);
                        fail_count++;
                    end
                    if (got.above_found !== want.above_found)
                    begin
                        $error("above_found: expected %0d, got %0d",
                               want.above_found, got.above_found);
                        fail_count++;
                    end
                end
            end
            if (query_ch.valid && query_ch.ready)
            begin
                if (offer_fixed)
                    owed_primes.push_back(offer_want);
                else
                    owed_primes.push_back(nearest_primes(query_ch.query_value));
            end
        end
    end

    // Receiver back-pressure. Each time rx_phase wraps, a new mode is drawn:
    // always ready, a random 16-bit pattern, ready when the low three phase bits
    // are zero, or a coin toss each cycle. The always-ready mode gives stretches with no stalls.
    rx_mode_t    rx_mode    = RX_ALWAYS;
    logic [15:0] rx_pattern = '1;
    logic [7:0]  rx_phase   = '0;

    always @(posedge clk)
    begin
        if (rx_phase == 8'd0)
        begin
            rx_mode    <= rx_mode_t'($urandom_range(0, 3));
            rx_pattern <= 16'($urandom);
        end
        rx_phase <= rx_phase + 8'd1;
        case (rx_mode)
            RX_ALWAYS:  result_ch.ready <= 1'b1;
            RX_PATTERN: result_ch.ready <= rx_pattern[rx_phase[3:0]];
            RX_SPARSE:  result_ch.ready <= (rx_phase[2:0] == 3'd0);
            default:    result_ch.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Sender bursts: before each item, once the current burst is used up,
    // the channel may fall idle for a random gap and a new burst length is
    // drawn. A gap of zero keeps valid high across the burst boundary.
    int unsigned burst_left = 0;

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                query_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 6);
        end
        burst_left--;
    endtask

    // Present one query and hold it until the block takes it.
    task automatic offer_query(value_t q, logic fixed, prime_pair_t want);
        query_ch.valid       <= 1'b1;
        query_ch.query_value <= q;
        offer_fixed          <= fixed;
        offer_want           <= want;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        query_ch.valid       = 1'b0;
        query_ch.query_value = '0;
        result_ch.ready      = 1'b0;
        offer_fixed          = 1'b0;
        offer_want           = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part first, then random queries.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            pace_sender();
            offer_query(directed_rows[i].query_value, directed_rows[i].fixed,
                        directed_rows[i].want);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pace_sender();
            offer_query(pick_query(), 1'b0, '0);
        end
        query_ch.valid <= 1'b0;
        // The checker queues the last query at the same edge that ended the
        // offer, so step to the next edge before looking at the queue.
        @(posedge clk);

        // Wait for every owed result; the watchdog covers a block that
        // never delivers. Then give any stray result time to show up.
        while (owed_primes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
